[src/four_channel_counter_timer_core_assert.svh]
// Assertion macros for the counter/timer core checker.
`ifndef FOUR_CHANNEL_COUNTER_TIMER_CORE_ASSERT_SVH
`define FOUR_CHANNEL_COUNTER_TIMER_CORE_ASSERT_SVH

// Same-cycle implication, idle during reset.
`define CTC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, idle during reset.
`define CTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ctc_pkg.sv]
// Shared types and constants for the four-channel counter/timer.
`default_nettype none

package ctc_pkg;

    localparam int CTC_NUM_CHANNELS = 4;

    localparam int FUNC_W  = 3;
    localparam int CHAN_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 16;
    localparam int TC_W    = 9;
    localparam int FLAG_W  = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE = 3'd0,
        FUNC_READ  = 3'd1,
        FUNC_TICK  = 3'd2,
        FUNC_ACK   = 3'd3,
        FUNC_RETI  = 3'd4
    } ctc_func_t;

    // control word bits
    localparam logic [BYTE_W-1:0] MODE_INT_EN  = 8'h80;
    localparam logic [BYTE_W-1:0] MODE_PRE256  = 8'h20;
    localparam logic [BYTE_W-1:0] MODE_CONST   = 8'h04;
    localparam logic [BYTE_W-1:0] MODE_RESET   = 8'h02;
    localparam logic [BYTE_W-1:0] MODE_CONTROL = 8'h01;

    localparam logic [BYTE_W-1:0] VECTOR_MASK = 8'hf8;
    localparam logic [TC_W-1:0]   TC_MAX      = 9'h100;

    localparam logic [FLAG_W-1:0] FLAG_REQ  = 2'b01;
    localparam logic [FLAG_W-1:0] FLAG_SERV = 2'b10;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CHAN_W-1:0] channel;
        logic [BYTE_W-1:0] write_data;
        logic [BYTE_W-1:0] tick_cycles;
    } ctc_cmd_t;

    // decoded operation, already qualified by the pipeline step
    typedef struct packed {
        logic write;
        logic read;
        logic tick;
        logic ack;
        logic reti;
    } ctc_op_t;

    // per-channel events towards the interrupt chain and vector register
    typedef struct packed {
        logic req_set;
        logic flag_clr;
        logic plain_write;
    } ctc_chan_stat_t;

endpackage

`default_nettype wire

[src/ctc_if.sv]
// Valid/ready channel interfaces for command and response words.
`default_nettype none

interface ctc_cmd_if;
    import ctc_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [CHAN_W-1:0] channel;
    logic [BYTE_W-1:0] write_data;
    logic [BYTE_W-1:0] tick_cycles;

    modport source (output valid, func, channel, write_data, tick_cycles, input ready);
    modport sink   (input valid, func, channel, write_data, tick_cycles, output ready);
endinterface

interface ctc_rsp_if;
    import ctc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COUNT_W-1:0] read_data;
    logic [BYTE_W-1:0]         ack_vector;
    logic                      irq_request;

    modport source (output valid, read_data, ack_vector, irq_request, input ready);
    modport sink   (input valid, read_data, ack_vector, irq_request, output ready);
endinterface

`default_nettype wire

[src/ctc_channel.sv]
// One counter/timer channel: control word, time constant, prescaler and down counter.
`default_nettype none

module ctc_channel (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ctc_pkg::ctc_op_t                   op,
    input  logic                               sel,
    input  logic [ctc_pkg::BYTE_W-1:0]         write_data,
    input  logic [ctc_pkg::BYTE_W-1:0]         tick_cycles,
    output logic signed [ctc_pkg::COUNT_W-1:0] count,
    output ctc_pkg::ctc_chan_stat_t            stat
);
    import ctc_pkg::*;

    localparam logic signed [COUNT_W:0] SAT_LO = -17'sd32768;

    logic [BYTE_W-1:0]         mode_reg, mode_next;
    logic [TC_W-1:0]           tc_reg, tc_next;
    logic signed [COUNT_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0]         residue_reg, residue_next;

    logic [BYTE_W:0]           acc;
    logic [4:0]                quot;
    logic [BYTE_W-1:0]         rem;
    logic signed [COUNT_W:0]   diff;
    logic signed [COUNT_W:0]   sat;
    logic signed [COUNT_W:0]   wrapped;
    logic                      underflow;
    logic [TC_W-1:0]           tc_load;

    // prescaler and down counter for a tick
    always_comb
    begin
        acc = {1'b0, residue_reg} + {1'b0, tick_cycles};
        if ((mode_reg & MODE_PRE256) != '0)
        begin
            quot = {4'b0, acc[8]};
            rem  = acc[7:0];
        end
        else
        begin
            quot = acc[8:4];
            rem  = {4'b0, acc[3:0]};
        end
        diff      = $signed({count_reg[COUNT_W-1], count_reg}) - $signed({12'b0, quot});
        sat       = (diff < SAT_LO) ? SAT_LO : diff;
        underflow = (sat <= 17'sd0);
        wrapped   = sat + $signed({8'b0, tc_reg});
        tc_load   = (write_data == '0) ? TC_MAX : {1'b0, write_data};
    end

    always_comb
    begin
        mode_next        = mode_reg;
        tc_next          = tc_reg;
        count_next       = count_reg;
        residue_next     = residue_reg;
        stat.req_set     = 1'b0;
        stat.flag_clr    = 1'b0;
        stat.plain_write = 1'b0;

        if (op.write && sel)
        begin
            if ((mode_reg & MODE_CONST) != '0)
            begin
                tc_next    = tc_load;
                mode_next  = mode_reg & ~(MODE_CONST | MODE_RESET);
                count_next = $signed({7'b0, tc_load});
            end
            else if ((write_data & MODE_CONTROL) != '0)
            begin
                mode_next     = write_data;
                stat.flag_clr = (write_data & MODE_RESET) != '0;
            end
            else
            begin
                stat.plain_write = 1'b1;
            end
        end

        if (op.tick)
        begin
            residue_next = rem;
            count_next   = underflow ? wrapped[COUNT_W-1:0] : sat[COUNT_W-1:0];
            stat.req_set = underflow && ((mode_reg & MODE_INT_EN) != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_RESET;
            tc_reg      <= TC_MAX;
            count_reg   <= '0;
            residue_reg <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            tc_reg      <= tc_next;
            count_reg   <= count_next;
            residue_reg <= residue_next;
        end
    end

    assign count = count_reg;

endmodule

`default_nettype wire

[src/ctc_irq_chain.sv]
// Interrupt daisy chain: request and in-service flags, acknowledge and return.
`default_nettype none

module ctc_irq_chain #(
    parameter  int NUM_CHANNELS = ctc_pkg::CTC_NUM_CHANNELS,
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctc_pkg::ctc_op_t        op,
    input  logic [NUM_CHANNELS-1:0] req_set,
    input  logic [NUM_CHANNELS-1:0] flag_clr,
    output logic [CH_W-1:0]         ack_channel,
    output logic                    pending
);
    import ctc_pkg::*;

    logic [FLAG_W-1:0] flags_reg  [NUM_CHANNELS];
    logic [FLAG_W-1:0] flags_next [NUM_CHANNELS];

    logic active_found;
    logic serv_found;
    logic pend_found;

    // highest-priority channel with any flag set (channel 0 first)
    always_comb
    begin
        active_found = 1'b0;
        ack_channel  = '0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            if (!active_found && (flags_reg[c] != '0))
            begin
                active_found = 1'b1;
                ack_channel  = CH_W'(c);
            end
        end
    end

    always_comb
    begin
        serv_found = 1'b0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            flags_next[c] = flags_reg[c];
            if (op.tick && req_set[c])
            begin
                flags_next[c] = flags_reg[c] | FLAG_REQ;
            end
            if (op.write && flag_clr[c])
            begin
                flags_next[c] = '0;
            end
            if (op.reti && !serv_found && ((flags_reg[c] & FLAG_SERV) != '0))
            begin
                serv_found    = 1'b1;
                flags_next[c] = flags_reg[c] & ~FLAG_SERV;
            end
        end
        if (op.ack && active_found && ((flags_reg[ack_channel] & FLAG_REQ) != '0))
        begin
            flags_next[ack_channel] = FLAG_SERV;
        end
    end

    // request line as seen after this word
    always_comb
    begin
        pend_found = 1'b0;
        pending    = 1'b0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            if (!pend_found && (flags_next[c] != '0))
            begin
                pend_found = 1'b1;
                pending    = (flags_next[c] == FLAG_REQ);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                flags_reg[c] <= '0;
            end
        end
        else
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                flags_reg[c] <= flags_next[c];
            end
        end
    end

endmodule

`default_nettype wire

[src/four_channel_counter_timer_core.sv]
// Top level of the four-channel counter/timer with daisy-chained interrupt request.
//
// Each command word (register write, counter read, tick, interrupt acknowledge or
// return from interrupt) is captured in an input register, then applied to all
// channels and to the interrupt chain together, and its response word is held in
// an output register. Throughput is one word per clock while the response side
// is not stalled; a word's response is registered when the word leaves the input
// register, which happens once the output register is free or being taken. While a
// finished response waits, the command side takes one more word into an empty
// input register and then holds ready low until the response is taken. The
// combinational work on a word is set by the tick path of each channel (prescaler
// add, counter subtract with saturation, reload add) and by the priority walk over
// the interrupt flags that produces the request line after the word has been
// applied. Writes to a channel number at or above NUM_CHANNELS are ignored and
// reads of it return zero.
`default_nettype none

module four_channel_counter_timer_core #(
    parameter  int NUM_CHANNELS = ctc_pkg::CTC_NUM_CHANNELS,
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic      clk,
    input  logic      rst_n,
    ctc_cmd_if.sink   cmd,
    ctc_rsp_if.source rsp
);
    import ctc_pkg::*;

    // input register
    logic     cmd_valid_reg;
    ctc_cmd_t cmd_reg;

    // output register
    logic                      rsp_valid_reg;
    logic signed [COUNT_W-1:0] read_data_reg;
    logic [BYTE_W-1:0]         ack_vector_reg;
    logic                      irq_request_reg;

    logic [BYTE_W-1:0] vector_base_reg;

    logic    advance;
    logic    step;
    ctc_op_t op;

    logic [NUM_CHANNELS-1:0]   sel;
    logic signed [COUNT_W-1:0] counts [NUM_CHANNELS];
    ctc_chan_stat_t            stats  [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]   req_set;
    logic [NUM_CHANNELS-1:0]   flag_clr;

    logic [CH_W-1:0]           ack_channel;
    logic                      pending;
    logic signed [COUNT_W-1:0] read_mux;
    logic [BYTE_W-1:0]         ack_vector;

    // the held word moves on whenever the response register is free or being taken
    assign advance   = !rsp_valid_reg || rsp.ready;
    assign step      = cmd_valid_reg && advance;
    assign cmd.ready = !cmd_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            cmd_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_reg.func        <= cmd.func;
            cmd_reg.channel     <= cmd.channel;
            cmd_reg.write_data  <= cmd.write_data;
            cmd_reg.tick_cycles <= cmd.tick_cycles;
        end
    end

    // function decode; unused codes do nothing
    always_comb
    begin
        op = '0;
        unique case (ctc_func_t'(cmd_reg.func))
            FUNC_WRITE: op.write = step;
            FUNC_READ:  op.read  = step;
            FUNC_TICK:  op.tick  = step;
            FUNC_ACK:   op.ack   = step;
            FUNC_RETI:  op.reti  = step;
            default:    op       = '0;
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < NUM_CHANNELS; gi++)
        begin : g_chan
            assign sel[gi] = (int'(cmd_reg.channel) == gi);

            ctc_channel u_channel (
                .clk         (clk),
                .rst_n       (rst_n),
                .op          (op),
                .sel         (sel[gi]),
                .write_data  (cmd_reg.write_data),
                .tick_cycles (cmd_reg.tick_cycles),
                .count       (counts[gi]),
                .stat        (stats[gi])
            );

            assign req_set[gi]  = stats[gi].req_set;
            assign flag_clr[gi] = stats[gi].flag_clr;
        end
    endgenerate

    ctc_irq_chain #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_irq_chain (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .req_set     (req_set),
        .flag_clr    (flag_clr),
        .ack_channel (ack_channel),
        .pending     (pending)
    );

    // vector register: a plain byte (bit 0 clear) written to channel 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vector_base_reg <= '0;
        end
        else if (stats[0].plain_write)
        begin
            vector_base_reg <= cmd_reg.write_data & VECTOR_MASK;
        end
    end

    // counter read of the addressed channel
    always_comb
    begin
        read_mux = '0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            if (op.read && sel[c])
            begin
                read_mux = counts[c];
            end
        end
    end

    // vector plus twice the serviced channel, modulo 256
    assign ack_vector = op.ack ? (vector_base_reg + BYTE_W'({ack_channel, 1'b0})) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            read_data_reg   <= read_mux;
            ack_vector_reg  <= ack_vector;
            irq_request_reg <= pending;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_data   = read_data_reg;
    assign rsp.ack_vector  = ack_vector_reg;
    assign rsp.irq_request = irq_request_reg;

endmodule

`default_nettype wire

[src/ctc_checker.sv]
// Port-level checker for the counter/timer core, bound to the top level.
`default_nettype none

`include "four_channel_counter_timer_core_assert.svh"

module ctc_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               cmd_valid,
    input wire logic                               cmd_ready,
    input wire logic                               rsp_valid,
    input wire logic                               rsp_ready,
    input wire logic signed [ctc_pkg::COUNT_W-1:0] rsp_read_data,
    input wire logic [ctc_pkg::BYTE_W-1:0]         rsp_ack_vector,
    input wire logic                               rsp_irq_request
);
    import ctc_pkg::*;

    // with no response held the command side must be open
    `CTC_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !rsp_valid, cmd_ready, "command stalled with empty response register")

    // an accepted word followed by a free response side yields a response word
    `CTC_ASSERT_NEXT(a_word_delivered, clk, rst_n, (cmd_valid && cmd_ready) ##1 rsp_ready, rsp_valid, "accepted word produced no response")

    // a read and an acknowledge never share a response word
    `CTC_ASSERT_NOW(a_fields_exclusive, clk, rst_n, rsp_valid, (rsp_read_data == '0) || (rsp_ack_vector == '0), "read data and vector both set")

    // a stalled response word holds
    `CTC_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_data) && $stable(rsp_ack_vector) && $stable(rsp_irq_request), "stalled response changed")

endmodule

bind four_channel_counter_timer_core ctc_checker u_ctc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_read_data   (rsp.read_data),
    .rsp_ack_vector  (rsp.ack_vector),
    .rsp_irq_request (rsp.irq_request)
);

`default_nettype wire
